FILE: rtl/rcc_pkg.sv
// Shared types and constants for the rotor cascade cipher core.
// No dependencies; imported by rcc_rotor_bank and rotor_cascade_cipher_core.
`timescale 1ns / 1ps

package rcc_pkg;

    localparam int LETTER_COUNT = 26;
    localparam int ROTOR_MAX    = 5;

    localparam int LETTER_W    = $clog2(LETTER_COUNT);
    localparam int ROTOR_IDX_W = (ROTOR_MAX > 1) ? $clog2(ROTOR_MAX) : 1;
    localparam int ROTOR_CNT_W = $clog2(ROTOR_MAX + 1);

    localparam logic [7:0]          CHAR_A     = 8'd65;
    localparam logic [LETTER_W-1:0] LETTER_MAX = LETTER_W'(LETTER_COUNT - 1);

    // Configuration register indexes (word address bit 2)
    localparam logic REG_ROTOR_COUNT = 1'b0;

    localparam logic [2:0] ROTOR_COUNT_RESET = 3'd1;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ENCODE  = 2'd1,
        CMD_DECODE  = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    // Word presented to the rotor bank from the input stage
    typedef struct packed {
        logic       fire;
        cmd_t       cmd;
        logic [2:0] rsel;
        logic [4:0] pos;
        logic [7:0] ch;
    } rcc_req_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       substituted;
    } rcc_res_t;

endpackage

FILE: rtl/rotor_cascade_cipher_core.sv
// Top level of the rotor cascade cipher: input stage, result register, APB register.
// Depends on rcc_pkg and rcc_rotor_bank.
`timescale 1ns / 1ps
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  --------------------------------------------
//  in       in_valid / in_ready        command, rotor_select, table_position, char_in
//  out      out_valid / out_ready      char_out, substituted
//  cfg      psel/penable/pwrite/pready paddr[2:0], pwdata, prdata (rotor_count @ 0x0)
//
//  One word per cycle while no coded word is held by a stalled output.
//  Input register feeds one pass of table lookups and the odometer step, then
//  the result register. Load and restart words produce no output word.
//  A stalled output holds the input register only when it holds a coding word.
//  Reset restores identity tables, clears the odometer and sets rotor_count to 1.

module rotor_cascade_cipher_core
    import rcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [2:0]  rotor_select,
    input  logic [4:0]  table_position,
    input  logic [7:0]  char_in,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_out,
    output logic        substituted,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       s1_valid_reg;
    cmd_t       s1_cmd_reg;
    logic [2:0] s1_rsel_reg;
    logic [4:0] s1_pos_reg;
    logic [7:0] s1_ch_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] char_out_reg;
    logic       substituted_reg;

    logic [2:0] rotor_count_reg;

    logic       s1_has_result;
    logic       s1_advance;
    logic       in_fire;
    rcc_req_t   req;
    rcc_res_t   res;

    assign s1_has_result = (s1_cmd_reg == CMD_ENCODE) || (s1_cmd_reg == CMD_DECODE);
    assign s1_advance    = s1_valid_reg && (!s1_has_result || !out_valid_reg || out_ready);
    assign in_ready      = !s1_valid_reg || s1_advance;
    assign in_fire       = in_valid && in_ready;

    assign req.fire = s1_advance;
    assign req.cmd  = s1_cmd_reg;
    assign req.rsel = s1_rsel_reg;
    assign req.pos  = s1_pos_reg;
    assign req.ch   = s1_ch_reg;

    rcc_rotor_bank u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .rotor_count (rotor_count_reg),
        .req         (req),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg  <= cmd_t'(command);
            s1_rsel_reg <= rotor_select;
            s1_pos_reg  <= table_position;
            s1_ch_reg   <= char_in;
        end
    end

    always_comb
    begin
        if (s1_advance && s1_has_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_has_result)
        begin
            char_out_reg    <= res.char_out;
            substituted_reg <= res.substituted;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;
    assign substituted = substituted_reg;

    // APB register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rotor_count_reg <= ROTOR_COUNT_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_ROTOR_COUNT))
            rotor_count_reg <= pwdata[2:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROTOR_COUNT) ? {29'd0, rotor_count_reg} : 32'd0;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_has_result) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_out_from_coding: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_advance && s1_has_result))
        else $error("output word without a coding word");

endmodule

FILE: rtl/rcc_rotor_bank.sv
// Rotor tables (forward and inverse), odometer digits and the coding cascade.
// Depends on rcc_pkg.
`timescale 1ns / 1ps

module rcc_rotor_bank
    import rcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] rotor_count,
    input  rcc_req_t   req,
    output rcc_res_t   res
);

    letter_t fwd_reg [ROTOR_MAX][LETTER_COUNT];
    letter_t inv_reg [ROTOR_MAX][LETTER_COUNT];
    logic [ROTOR_MAX-1:0][LETTER_W-1:0] digit_reg;
    logic [ROTOR_MAX-1:0][LETTER_W-1:0] digit_next;

    logic                   is_letter;
    logic [8:0]             ch_ext;
    logic [7:0]             ch_off;
    letter_t                in_letter;
    logic                   load_ok;
    logic [ROTOR_IDX_W-1:0] load_rotor;
    letter_t                load_pos;
    logic [ROTOR_CNT_W-1:0] n_active;
    letter_t                enc_v;
    letter_t                dec_v;
    logic                   advance;

    assign ch_ext    = {1'b0, req.ch};
    assign is_letter = (ch_ext >= 9'(CHAR_A)) && (ch_ext < 9'(CHAR_A) + 9'(LETTER_COUNT));
    assign ch_off    = req.ch - CHAR_A;
    assign in_letter = ch_off[LETTER_W-1:0];

    assign load_rotor = req.rsel[ROTOR_IDX_W-1:0];
    assign load_pos   = req.pos[LETTER_W-1:0];
    assign load_ok    = req.fire && (req.cmd == CMD_LOAD) && (req.rsel < ROTOR_MAX)
                        && (req.pos < LETTER_COUNT) && is_letter;

    // 0 acts as one rotor, anything above the maximum as the maximum
    always_comb
    begin
        if (rotor_count == 3'd0)
            n_active = ROTOR_CNT_W'(1);
        else if (rotor_count > ROTOR_MAX)
            n_active = ROTOR_CNT_W'(ROTOR_MAX);
        else
            n_active = ROTOR_CNT_W'(rotor_count);
    end

    // Encode: rotors 0 .. n-1, offset added before the lookup
    always_comb
    begin
        logic [LETTER_W:0] sum;
        enc_v = in_letter;
        for (int k = 0; k < ROTOR_MAX; k++)
        begin
            sum = {1'b0, enc_v} + {1'b0, digit_reg[k]};
            if (sum >= (LETTER_W+1)'(LETTER_COUNT))
                sum = sum - (LETTER_W+1)'(LETTER_COUNT);
            if (ROTOR_CNT_W'(k) < n_active)
                enc_v = fwd_reg[k][sum[LETTER_W-1:0]];
        end
    end

    // Decode: rotors n-1 .. 0, offset subtracted after the inverse lookup
    always_comb
    begin
        logic [LETTER_W:0] diff;
        dec_v = in_letter;
        for (int k = ROTOR_MAX - 1; k >= 0; k--)
        begin
            diff = {1'b0, inv_reg[k][dec_v]} - {1'b0, digit_reg[k]};
            if (inv_reg[k][dec_v] < digit_reg[k])
                diff = diff + (LETTER_W+1)'(LETTER_COUNT);
            if (ROTOR_CNT_W'(k) < n_active)
                dec_v = diff[LETTER_W-1:0];
        end
    end

    assign advance = req.fire && is_letter
                     && ((req.cmd == CMD_ENCODE) || (req.cmd == CMD_DECODE));

    // Odometer: ripple carry, top digit wraps
    always_comb
    begin
        logic carry;
        carry      = 1'b1;
        digit_next = digit_reg;
        for (int k = 0; k < ROTOR_MAX; k++)
        begin
            if (carry)
            begin
                if (digit_reg[k] == LETTER_MAX)
                    digit_next[k] = '0;
                else
                begin
                    digit_next[k] = digit_reg[k] + letter_t'(1);
                    carry         = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (!is_letter)
        begin
            res.char_out    = req.ch;
            res.substituted = 1'b0;
        end
        else
        begin
            res.char_out    = CHAR_A + 8'((req.cmd == CMD_DECODE) ? dec_v : enc_v);
            res.substituted = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else if (req.fire && (req.cmd == CMD_RESTART))
        begin
            digit_reg <= '0;
        end
        else if (advance)
        begin
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROTOR_MAX; r++)
            begin
                for (int p = 0; p < LETTER_COUNT; p++)
                begin
                    fwd_reg[r][p] <= LETTER_W'(p);
                    inv_reg[r][p] <= LETTER_W'(p);
                end
            end
        end
        else if (load_ok)
        begin
            fwd_reg[load_rotor][load_pos]  <= in_letter;
            inv_reg[load_rotor][in_letter] <= load_pos;
        end
    end

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req.fire && (req.cmd == CMD_RESTART)) |=> (digit_reg == '0))
        else $error("odometer not cleared by restart");

    a_load_keeps_odometer: assert property (@(posedge clk) disable iff (!rst_n)
        (req.fire && (req.cmd == CMD_LOAD)) |=> $stable(digit_reg))
        else $error("table load moved the odometer");

    a_letter_steps: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (digit_reg[0] != $past(digit_reg[0])))
        else $error("coded letter did not step the odometer");

endmodule

FILE: tb/rotor_cascade_cipher_checker.sv
// Checker for the rotor cascade cipher core: tracks rotor tables, odometer and
// rotor_count, predicts each output word and compares it. Depends on rcc_pkg.
`timescale 1ns / 1ps

module rotor_cascade_cipher_checker
    import rcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  command,
    input  logic [2:0]  rotor_select,
    input  logic [4:0]  table_position,
    input  logic [7:0]  char_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  char_out,
    input  logic        substituted,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          letters_coded,
    output int          chars_passed,
    output int          entries_loaded
);

    letter_t    fwd_map  [ROTOR_MAX][LETTER_COUNT];
    letter_t    inv_map  [ROTOR_MAX][LETTER_COUNT];
    letter_t    odometer [ROTOR_MAX];
    logic [2:0] rotor_count;
    rcc_res_t   coded_q [$];
    rcc_res_t   want;
    int         mismatches;
    int         n_coded;
    int         n_passed;
    int         n_loaded;

    task automatic clear_cipher_state();
        int r;
        int p;
        for (r = 0; r < ROTOR_MAX; r++)
        begin
            for (p = 0; p < LETTER_COUNT; p++)
            begin
                fwd_map[r][p] = letter_t'(p);
                inv_map[r][p] = letter_t'(p);
            end
            odometer[r] = '0;
        end
        rotor_count = ROTOR_COUNT_RESET;
        coded_q.delete();
    endtask

    task automatic cipher_word(input cmd_t cmd, input logic [2:0] rsel,
                               input logic [4:0] pos, input logic [7:0] ch);
        int  n;
        int  v;
        int  k;
        bit  letter;
        bit  carry;
        n = (rotor_count == 0) ? 1 : (rotor_count > ROTOR_MAX) ? ROTOR_MAX : int'(rotor_count);
        letter = (ch >= CHAR_A) && (ch < CHAR_A + LETTER_COUNT);
        case (cmd)
            CMD_LOAD:
            begin
                if (rsel < ROTOR_MAX && pos < LETTER_COUNT && letter)
                begin
                    v = ch - CHAR_A;
                    fwd_map[rsel][pos] = letter_t'(v);
                    inv_map[rsel][v] = letter_t'(pos);
                    n_loaded++;
                end
            end
            CMD_RESTART:
            begin
                for (k = 0; k < ROTOR_MAX; k++)
                    odometer[k] = '0;
            end
            default:
            begin
                if (!letter)
                begin
                    coded_q.insert(coded_q.size(),
                                   rcc_res_t'{char_out: ch, substituted: 1'b0});
                    n_passed++;
                end
                else
                begin
                    v = ch - CHAR_A;
                    if (cmd == CMD_ENCODE)
                    begin
                        for (k = 0; k < n; k++)
                            v = fwd_map[k][(v + odometer[k]) % LETTER_COUNT];
                    end
                    else
                    begin
                        for (k = n - 1; k >= 0; k--)
                            v = (inv_map[k][v] + LETTER_COUNT - odometer[k]) % LETTER_COUNT;
                    end
                    // odometer step, top digit wraps
                    carry = 1'b1;
                    for (k = 0; k < ROTOR_MAX; k++)
                    begin
                        if (carry)
                        begin
                            if (odometer[k] == LETTER_MAX)
                                odometer[k] = '0;
                            else
                            begin
                                odometer[k] = odometer[k] + 1'b1;
                                carry = 1'b0;
                            end
                        end
                    end
                    coded_q.insert(coded_q.size(),
                                   rcc_res_t'{char_out: 8'(CHAR_A + v), substituted: 1'b1});
                    n_coded++;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cipher_state();
            mismatches = 0;
            n_coded = 0;
            n_passed = 0;
            n_loaded = 0;
        end
        else
        begin
            // output first: a word accepted at this edge cannot be answered at it
            if (out_valid && out_ready)
            begin
                if (coded_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected output word, expected none, got char_out=%h substituted=%b",
                             $time, char_out, substituted);
                end
                else
                begin
                    want = coded_q.pop_front();
                    if (char_out !== want.char_out)
                    begin
                        mismatches++;
                        $display("%0t: char_out mismatch, expected %h, got %h",
                                 $time, want.char_out, char_out);
                    end
                    if (substituted !== want.substituted)
                    begin
                        mismatches++;
                        $display("%0t: substituted mismatch, expected %b, got %b",
                                 $time, want.substituted, substituted);
                    end
                end
            end
            if (in_valid && in_ready)
                cipher_word(cmd_t'(command), rotor_select, table_position, char_in);
            if (psel && penable && pwrite && pready && paddr == {REG_ROTOR_COUNT, 2'b00})
                rotor_count = pwdata[2:0];
        end
        fail_count     <= mismatches;
        pending        <= coded_q.size();
        letters_coded  <= n_coded;
        chars_passed   <= n_passed;
        entries_loaded <= n_loaded;
    end

endmodule

FILE: tb/rotor_cascade_cipher_core_test.sv
// Top of the rotor cascade cipher core testbench: clock, reset, stimulus, verdict.
// Depends on rcc_pkg, rotor_cascade_cipher_core and rotor_cascade_cipher_checker.
`timescale 1ns / 1ps

module rotor_cascade_cipher_core_test;
    import rcc_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASES       = 8;
    localparam int MSG_WORDS    = 135;
    // rotor_count per phase, phase 0 in the low bits
    localparam logic [23:0] COUNT_PLAN =
        {3'd1, 3'd6, 3'd4, 3'd2, 3'd3, 3'd7, 3'd0, 3'd5};

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [1:0]  command        = CMD_LOAD;
    logic [2:0]  rotor_select   = 3'd0;
    logic [4:0]  table_position = 5'd0;
    logic [7:0]  char_in        = 8'd0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [7:0]  char_out;
    logic        substituted;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = 3'd0;
    logic [31:0] pwdata         = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int letters_coded;
    int chars_passed;
    int entries_loaded;
    int send_idle   = 0;
    int recv_stall  = 0;
    int cycle_count = 0;

    rotor_cascade_cipher_core DUT (.*);

    rotor_cascade_cipher_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("rotor_cascade_cipher_core test failed");
        $finish;
    end

    task automatic send_word(input cmd_t cmd, input logic [2:0] rsel,
                             input logic [4:0] pos, input logic [7:0] ch);
        in_valid       <= 1'b1;
        command        <= cmd;
        rotor_select   <= rsel;
        table_position <= pos;
        char_in        <= ch;
        do @(posedge clk); while (!in_ready);
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
        end
    endtask

    // stop sending and wait for every coded word to come out
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_rotor_count(input logic [2:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROTOR_COUNT, 2'b00};
        pwdata  <= {29'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_permutation(input logic [2:0] rotor);
        int perm [LETTER_COUNT];
        int p;
        int j;
        int t;
        for (p = 0; p < LETTER_COUNT; p++)
            perm[p] = p;
        for (p = LETTER_COUNT - 1; p > 0; p--)
        begin
            j = $urandom_range(0, p);
            t = perm[p];
            perm[p] = perm[j];
            perm[j] = t;
        end
        for (p = 0; p < LETTER_COUNT; p++)
            send_word(CMD_LOAD, rotor, 5'(p), 8'(CHAR_A + perm[p]));
    endtask

    task automatic random_word(input bit restarts_ok);
        int         pick;
        cmd_t       cmd;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        cmd = $urandom_range(0, 1) ? CMD_ENCODE : CMD_DECODE;
        if (pick < 70 || (pick < 88 && pick >= 82 && !restarts_ok))
            send_word(cmd, 3'($urandom), 5'($urandom), 8'(CHAR_A + $urandom_range(0, 25)));
        else if (pick < 82)
        begin
            do ch = 8'($urandom); while (ch >= CHAR_A && ch < CHAR_A + LETTER_COUNT);
            send_word(cmd, 3'($urandom), 5'($urandom), ch);
        end
        else if (pick < 88)
            send_word(CMD_RESTART, 3'($urandom), 5'($urandom), 8'($urandom));
        else if (pick < 93)
            // lone entry, the table stops being a permutation
            send_word(CMD_LOAD, 3'($urandom_range(0, ROTOR_MAX - 1)),
                      5'($urandom_range(0, LETTER_COUNT - 1)),
                      8'(CHAR_A + $urandom_range(0, 25)));
        else
        begin
            cmd = cmd_t'($urandom_range(0, 3));
            if (cmd == CMD_RESTART && !restarts_ok)
                cmd = CMD_DECODE;
            send_word(cmd, 3'($urandom), 5'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int phase;
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words with one rotor, starting from identity tables
        send_word(CMD_ENCODE, 3'd0, 5'd0, "A");
        send_word(CMD_ENCODE, 3'd0, 5'd0, "Z");
        send_word(CMD_DECODE, 3'd0, 5'd0, "A");
        send_word(CMD_ENCODE, 3'd0, 5'd0, 8'd64);
        send_word(CMD_ENCODE, 3'd0, 5'd0, 8'd91);
        send_word(CMD_DECODE, 3'd7, 5'd31, 8'h00);
        send_word(CMD_DECODE, 3'd0, 5'd0, 8'hff);
        send_word(CMD_LOAD, 3'd0, 5'd0, "Z");
        send_word(CMD_LOAD, 3'd4, 5'd25, "A");
        send_word(CMD_LOAD, 3'd5, 5'd0, "B");
        send_word(CMD_LOAD, 3'd7, 5'd31, "C");
        send_word(CMD_LOAD, 3'd0, 5'd26, "C");
        send_word(CMD_LOAD, 3'd0, 5'd31, "C");
        send_word(CMD_LOAD, 3'd1, 5'd3, 8'd64);
        send_word(CMD_LOAD, 3'd1, 5'd3, 8'hff);
        send_word(CMD_RESTART, 3'd7, 5'd31, 8'hff);
        send_word(CMD_ENCODE, 3'd0, 5'd0, "A");
        send_word(CMD_DECODE, 3'd0, 5'd0, "Z");
        send_word(CMD_RESTART, 3'd0, 5'd0, 8'h00);
        send_word(CMD_DECODE, 3'd0, 5'd0, "Z");

        // no restarts in early phases so the odometer carries into its second digit many times
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain(DRAIN_CYCLES);
            write_rotor_count(COUNT_PLAN[3 * phase +: 3]);
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 63; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 63; end
                default: begin send_idle = 31; recv_stall = 31; end
            endcase
            load_permutation(3'(phase % ROTOR_MAX));
            if (phase >= 6)
                send_word(CMD_RESTART, 3'($urandom), 5'($urandom), 8'($urandom));
            for (i = 0; i < MSG_WORDS; i++)
            begin
                if (phase == 1 && i == MSG_WORDS / 2)
                    drain(0);
                random_word(phase >= 6);
            end
        end
        drain(DRAIN_CYCLES);

        $display("Covered %0d coded letters and %0d pass-through characters, %0d table entries",
                 letters_coded, chars_passed, entries_loaded);
        $display("loaded, rotor_count settings 0 through 7 under four handshake mixes.");
        if (fail_count == 0)
            $display("rotor_cascade_cipher_core test passed");
        else
            $display("rotor_cascade_cipher_core test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/rcc_pkg.sv
rtl/rcc_rotor_bank.sv
rtl/rotor_cascade_cipher_core.sv
tb/rotor_cascade_cipher_checker.sv
tb/rotor_cascade_cipher_core_test.sv
